>>> rtl/core/jset_pkg.sv
// ----------------------------------------------------------------------------
// Julia set escape time package
// Shared widths, fixed point constants, register indexes, reset values and
// the sequencer state type of the escape time core.
// ----------------------------------------------------------------------------
package jset_pkg;

   localparam int FRAC_BITS       = 28;
   localparam int COORD_WIDTH     = 32;
   localparam int COUNT_WIDTH     = 10;
   localparam int COL_WIDTH       = 12;
   localparam int ROW_WIDTH       = 12;
   localparam int PITCH_WIDTH     = COORD_WIDTH - 1;
   localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PROD_WIDTH-1:0]  wide_type;
   typedef logic [PITCH_WIDTH-1:0]        pitch_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [COL_WIDTH-1:0]          column_type;
   typedef logic [ROW_WIDTH-1:0]          row_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam wide_type WIDE_COORD_MAX =
      {{(PROD_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam wide_type WIDE_COORD_MIN =
      {{(PROD_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // Squared magnitude bound of 4.0 in the fixed point format.
   localparam logic [COORD_WIDTH:0] ESCAPE_LIMIT = (COORD_WIDTH+1)'(64'd4 << FRAC_BITS);

   localparam coord_type LEFT_EDGE_RE_RESET   = coord_type'(-268016026);
   localparam coord_type TOP_EDGE_IM_RESET    = coord_type'(267876216);
   localparam pitch_type PITCH_RE_RESET       = pitch_type'(838861);
   localparam pitch_type PITCH_IM_RESET       = pitch_type'(1118481);
   localparam coord_type SEED_RE_RESET        = coord_type'(-195124484);
   localparam coord_type SEED_IM_RESET        = coord_type'(50704002);
   localparam count_type MAX_ITERATIONS_RESET = count_type'(500);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEFT_EDGE_RE   = 3'd0,
      CSR_TOP_EDGE_IM    = 3'd1,
      CSR_PITCH_RE       = 3'd2,
      CSR_PITCH_IM       = 3'd3,
      CSR_SEED_RE        = 3'd4,
      CSR_SEED_IM        = 3'd5,
      CSR_MAX_ITERATIONS = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ORIGIN,
      ST_PLACE,
      ST_SQUARE,
      ST_SCALE,
      ST_TEST,
      ST_UPDATE,
      ST_FINISH
   } jset_state_type;

endpackage

>>> rtl/core/jset_req_if.sv
// ----------------------------------------------------------------------------
// Julia set pixel request channel
// Carries one pixel position per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface jset_req_if;
   import jset_pkg::*;

   logic       valid;
   logic       ready;
   column_type column;
   row_type    row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);

endinterface

>>> rtl/core/jset_rsp_if.sv
// ----------------------------------------------------------------------------
// Julia set escape result channel
// Carries one iteration count and escape flag per word with valid/ready.
// ----------------------------------------------------------------------------
interface jset_rsp_if;
   import jset_pkg::*;

   logic      valid;
   logic      ready;
   count_type iteration_count;
   logic      escaped;

   modport source (output valid, output iteration_count, output escaped, input ready);
   modport sink   (input valid, input iteration_count, input escaped, output ready);

endinterface

>>> rtl/core/julia_set_escape_time_core.sv
// ----------------------------------------------------------------------------
// Julia set escape time core
// Handles one pixel at a time: a new request is taken only in idle, once the
// result of the last one has been loaded into the response register. Each pass
// runs through the square, scale, test and update states, using the shared set
// of three 32x32 multipliers and its saturating adders.
// Reset (synchronous, active high) returns to idle with no response pending
// and loads the default view window, seed and iteration limit.
// ----------------------------------------------------------------------------
module julia_set_escape_time_core (
   input  logic                                 clock,
   input  logic                                 reset,
   jset_req_if.sink                             req_ch,
   jset_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [jset_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [jset_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);
   import jset_pkg::*;

   function automatic coord_type sat_coord(input wide_type v);
      coord_type r;
      if (v > WIDE_COORD_MAX) begin
         r = COORD_MAX;
      end else if (v < WIDE_COORD_MIN) begin
         r = COORD_MIN;
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

   coord_type left_edge_re_ff, top_edge_im_ff, seed_re_ff, seed_im_ff;
   pitch_type pitch_re_ff, pitch_im_ff;
   count_type max_iterations_ff;

   jset_state_type state_ff, state_in;

   column_type col_ff, col_in;
   row_type    row_ff, row_in;
   count_type  limit_ff, limit_in;
   count_type  count_ff, count_in;
   logic       started_ff, started_in;
   coord_type  x_ff, x_in, y_ff, y_in;
   coord_type  xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   coord_type  diff_ff, diff_in;
   wide_type   prod0_ff, prod0_in, prod1_ff, prod1_in, prod2_ff, prod2_in;
   count_type  res_count_ff, res_count_in;
   logic       res_esc_ff, res_esc_in;
   count_type  rsp_count_ff, rsp_count_in;
   logic       rsp_esc_ff, rsp_esc_in;
   logic       rsp_valid_ff, rsp_valid_in;

   coord_type  mul_a0, mul_b0, mul_a1, mul_b1;
   logic [COORD_WIDTH:0] mag_sum;
   logic       escape_hit;
   count_type  next_count;
   logic       limit_hit;
   logic       accept;
   logic       out_load;
   logic       req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_re_ff   <= LEFT_EDGE_RE_RESET;
         top_edge_im_ff    <= TOP_EDGE_IM_RESET;
         pitch_re_ff       <= PITCH_RE_RESET;
         pitch_im_ff       <= PITCH_IM_RESET;
         seed_re_ff        <= SEED_RE_RESET;
         seed_im_ff        <= SEED_IM_RESET;
         max_iterations_ff <= MAX_ITERATIONS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_EDGE_RE:   left_edge_re_ff   <= csr_wr_data[COORD_WIDTH-1:0];
            CSR_TOP_EDGE_IM:    top_edge_im_ff    <= csr_wr_data[COORD_WIDTH-1:0];
            CSR_PITCH_RE:       pitch_re_ff       <= csr_wr_data[PITCH_WIDTH-1:0];
            CSR_PITCH_IM:       pitch_im_ff       <= csr_wr_data[PITCH_WIDTH-1:0];
            CSR_SEED_RE:        seed_re_ff        <= csr_wr_data[COORD_WIDTH-1:0];
            CSR_SEED_IM:        seed_im_ff        <= csr_wr_data[COORD_WIDTH-1:0];
            CSR_MAX_ITERATIONS: max_iterations_ff <= csr_wr_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_ch.valid && req_ready;

   // The multiplier set forms the pixel offsets first and the squares after.
   always_comb begin
      if (state_ff == ST_ORIGIN) begin
         mul_a0 = coord_type'({{(COORD_WIDTH-COL_WIDTH){1'b0}}, col_ff});
         mul_b0 = coord_type'({1'b0, pitch_re_ff});
         mul_a1 = coord_type'({{(COORD_WIDTH-ROW_WIDTH){1'b0}}, row_ff});
         mul_b1 = coord_type'({1'b0, pitch_im_ff});
      end else begin
         mul_a0 = x_ff;
         mul_b0 = x_ff;
         mul_a1 = y_ff;
         mul_b1 = y_ff;
      end
   end

   assign prod0_in = PROD_WIDTH'(mul_a0) * PROD_WIDTH'(mul_b0);
   assign prod1_in = PROD_WIDTH'(mul_a1) * PROD_WIDTH'(mul_b1);
   assign prod2_in = PROD_WIDTH'(x_ff) * PROD_WIDTH'(y_ff);

   assign mag_sum    = {1'b0, xx_ff[COORD_WIDTH-1:0]} + {1'b0, yy_ff[COORD_WIDTH-1:0]};
   assign escape_hit = started_ff && (mag_sum > ESCAPE_LIMIT);
   assign next_count = started_ff ? count_ff + count_type'(1) : count_ff;
   assign limit_hit  = (next_count >= limit_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ORIGIN;
            end
         end
         ST_ORIGIN: state_in = ST_PLACE;
         ST_PLACE:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_TEST;
         ST_TEST: begin
            if (escape_hit || limit_hit) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_SQUARE;
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FINISH: out_load  = !rsp_valid_ff || rsp_ch.ready;
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      started_in   = started_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      xy_in        = xy_ff;
      diff_in      = diff_ff;
      res_count_in = res_count_ff;
      res_esc_in   = res_esc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            col_in     = req_ch.column;
            row_in     = req_ch.row;
            limit_in   = (max_iterations_ff == '0) ? '0
                                                   : max_iterations_ff - count_type'(1);
            count_in   = '0;
            started_in = 1'b0;
         end
         ST_PLACE: begin
            x_in = sat_coord(PROD_WIDTH'(left_edge_re_ff) +
                             PROD_WIDTH'(sat_coord(prod0_ff)));
            y_in = sat_coord(PROD_WIDTH'(top_edge_im_ff) +
                             PROD_WIDTH'(sat_coord(-prod1_ff)));
         end
         ST_SCALE: begin
            xx_in = sat_coord(prod0_ff >>> FRAC_BITS);
            yy_in = sat_coord(prod1_ff >>> FRAC_BITS);
            xy_in = sat_coord(prod2_ff >>> (FRAC_BITS - 1));
         end
         ST_TEST: begin
            diff_in    = sat_coord(PROD_WIDTH'(xx_ff) - PROD_WIDTH'(yy_ff));
            count_in   = next_count;
            started_in = 1'b1;
            if (escape_hit) begin
               res_count_in = count_ff;
               res_esc_in   = 1'b1;
            end else begin
               res_count_in = next_count;
               res_esc_in   = 1'b0;
            end
         end
         ST_UPDATE: begin
            x_in = sat_coord(PROD_WIDTH'(diff_ff) + PROD_WIDTH'(seed_re_ff));
            y_in = sat_coord(PROD_WIDTH'(xy_ff) + PROD_WIDTH'(seed_im_ff));
         end
         default: begin
         end
      endcase
   end

   assign rsp_count_in = out_load ? res_count_ff : rsp_count_ff;
   assign rsp_esc_in   = out_load ? res_esc_ff : rsp_esc_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      limit_ff     <= limit_in;
      count_ff     <= count_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      xy_ff        <= xy_in;
      diff_ff      <= diff_in;
      res_count_ff <= res_count_in;
      res_esc_ff   <= res_esc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_esc_ff   <= rsp_esc_in;
      if (state_ff == ST_ORIGIN || state_ff == ST_SQUARE) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
   end

   assign req_ch.ready           = req_ready;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.iteration_count = rsp_count_ff;
   assign rsp_ch.escaped         = rsp_esc_ff;

`ifndef NO_ASSERTIONS
   // The pass count never runs past the limit while a pixel is in work.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST || state_ff == ST_UPDATE || state_ff == ST_FINISH)
         |-> (count_ff <= limit_ff))
      else $error("pass count exceeded the iteration limit");

   // An accepted word starts the offset multiply in the next cycle.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_ORIGIN))
      else $error("accepted request did not start the sequencer");

   // A finished pixel reaches the response register without being dropped.
   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented on the response channel");
`endif

endmodule
